// File: src/vre_pkg.sv
// shared types and constants for the vector reduction engine
`default_nettype none

package vre_pkg;

  // fixed field, accumulator and mode widths and the queue depth
  localparam int unsigned ElemFieldW = 32;
  localparam int unsigned AccW       = 64;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned QueueDepth = 4;

  // reduction modes as held in the mode register
  typedef enum logic [ModeW-1:0] {
    MODE_DOT    = 3'd0,
    MODE_NORM2  = 3'd1,
    MODE_NORM1  = 3'd2,
    MODE_NORMINF = 3'd3,
    MODE_SUM    = 3'd4
  } mode_e;

  // what the back end does with one term
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_MAX  = 2'd2
  } op_e;

  // back end sequencer states
  typedef enum logic {
    BK_ACC  = 1'b0,
    BK_ROOT = 1'b1
  } back_state_e;

  // input item
  typedef struct packed {
    logic signed [ElemFieldW-1:0] x_elem;
    logic signed [ElemFieldW-1:0] y_elem;
    logic                         last_elem;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [AccW-1:0] reduced_value;
    logic                   saturated_flag;
  } out_item_t;

  // classified work item between front and back
  typedef struct packed {
    logic signed [AccW-1:0] term;
    op_e                    op;
    logic                   last;
    logic                   root;
  } work_t;

endpackage

`default_nettype wire

// File: src/vector_reduction_engine_unit.sv
// top level of the vector reduction engine
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_data_i) takes one element pair
//   per transfer; last_elem marks the final pair of a vector. The output channel
//   (out_valid_o, out_stall_i, out_data_o) gives one result per vector.
//   The user must write the mode register over cfg_valid_i / cfg_ready_o / cfg_data_i
//   only while the engine is idle; the block does not enforce it. Ready is always high.
// Flow:
//   One pair per cycle is taken while the work queue has room. A result passes
//   through the work queue and then the output register after its last pair;
//   in two-norm mode the bit-serial square root (one root bit a cycle) runs
//   between them. During the root the back end takes no new work and the
//   input keeps filling the four-entry queue, then stalls.
// Reset:
//   Mode returns to dot product, accumulator and overflow mark clear, the queue
//   empties and no result is valid.
// Receiver stall:
//   A result held in the output register stays unchanged until transferred;
//   the back end holds a last pair and the queue fills up, raising in_stall_o.
`default_nettype none

module vector_reduction_engine_unit import vre_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ModeW-1:0] cfg_data_i
);

  mode_e mode_q;
  work_t front_work;
  work_t queue_work;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;
  logic  push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;
  assign push        = in_valid_i && !queue_full;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DOT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  vre_front #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .item_i(in_data_i),
    .mode_i(mode_q),
    .work_o(front_work)
  );

  vre_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_work),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .data_o (queue_work)
  );

  vre_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_valid_i(queue_valid),
    .work_i      (queue_work),
    .work_pop_o  (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: src/vre_front.sv
// front end: decodes the mode and forms the per element term
`default_nettype none

module vre_front import vre_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  in_item_t item_i,
  input  mode_e    mode_i,
  output work_t    work_o
);

  logic signed [ELEM_WIDTH-1:0]   xs;
  logic signed [ELEM_WIDTH-1:0]   ys;
  logic signed [ELEM_WIDTH-1:0]   mul_b;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic        [ELEM_WIDTH-1:0]   ax;
  logic        [AccW-1:0]         ax_scaled;
  logic signed [AccW-1:0]         x_scaled;
  logic signed [AccW-1:0]         prod_ext;

  // element extraction and the single multiplier
  always_comb begin
    xs        = item_i.x_elem[ELEM_WIDTH-1:0];
    ys        = item_i.y_elem[ELEM_WIDTH-1:0];
    mul_b     = (mode_i == MODE_NORM2) ? xs : ys;
    prod      = xs * mul_b;
    prod_ext  = AccW'(prod);
    ax        = xs[ELEM_WIDTH-1] ? unsigned'(-xs) : unsigned'(xs);
    ax_scaled = AccW'(ax) << FRAC_BITS;
    x_scaled  = AccW'(xs) <<< FRAC_BITS;
  end

  // classify the item for the back end
  always_comb begin
    work_o.last = item_i.last_elem;
    work_o.root = (mode_i == MODE_NORM2);
    unique case (mode_i)
      MODE_DOT, MODE_NORM2: begin
        work_o.term = prod_ext;
        work_o.op   = OP_ADD;
      end
      MODE_NORM1: begin
        work_o.term = signed'(ax_scaled);
        work_o.op   = OP_ADD;
      end
      MODE_NORMINF: begin
        work_o.term = signed'(ax_scaled);
        work_o.op   = OP_MAX;
      end
      MODE_SUM: begin
        work_o.term = x_scaled;
        work_o.op   = OP_ADD;
      end
      default: begin
        work_o.term = '0;
        work_o.op   = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/vre_queue.sv
// short work queue between front and back end
`default_nettype none

module vre_queue import vre_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  work_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/vre_sqrt.sv
// bit serial integer square root of the scaled accumulator
`default_nettype none

module vre_sqrt import vre_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AccW-1:0] value_i,
  output logic                   busy_o,
  output logic        [AccW-1:0] root_o
);

  localparam int unsigned RadW  = AccW + 2 * FRAC_BITS;
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned CntW  = $clog2(RootW + 1);

  logic [RadW-1:0]    rad_q, rad_d;
  logic [RootW+1:0]   rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [RootW+1:0]   rem_sh;
  logic [RootW+1:0]   trial;
  logic [AccW-1:0]    start_val;

  assign busy_o = busy_q;
  assign root_o = AccW'(root_q);

  // one root bit per cycle, restoring form
  always_comb begin
    start_val = value_i[AccW-1] ? '0 : unsigned'(value_i);
    rem_sh    = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
    trial     = {root_q, 2'b01};
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    if (start_i) begin
      rad_d  = RadW'(start_val) << (2 * FRAC_BITS);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

`default_nettype wire

// File: src/vre_back.sv
// back end: saturating accumulate, root finish and output register
`default_nettype none

module vre_back import vre_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  input  work_t     work_i,
  output logic      work_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  back_state_e            state_q, state_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic                   flag_q, flag_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic signed [AccW:0]   sum;
  logic signed [AccW-1:0] acc_upd;
  logic                   ovf_upd;
  logic                   out_free;
  logic                   pop;
  logic                   root_start;
  logic                   out_load;
  logic                   sqrt_busy;
  logic        [AccW-1:0] sqrt_root;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign work_pop_o  = pop;

  // saturating add or running maximum for the head item
  always_comb begin
    sum     = {acc_q[AccW-1], acc_q} + {work_i.term[AccW-1], work_i.term};
    acc_upd = acc_q;
    ovf_upd = ovf_q;
    unique case (work_i.op)
      OP_ADD: begin
        if (sum[AccW] != sum[AccW-1]) begin
          acc_upd = sum[AccW] ? AccMin : AccMax;
          ovf_upd = 1'b1;
        end else begin
          acc_upd = sum[AccW-1:0];
        end
      end
      OP_MAX: begin
        if (work_i.term > acc_q) begin
          acc_upd = work_i.term;
        end
      end
      default: begin
        acc_upd = acc_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_ACC: begin
        if (work_valid_i && work_i.last && work_i.root && out_free) begin
          state_d = BK_ROOT;
        end
      end
      BK_ROOT: begin
        if (!sqrt_busy && out_free) begin
          state_d = BK_ACC;
        end
      end
      default: state_d = BK_ACC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop        = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    out_d      = out_q;
    unique case (state_q)
      BK_ACC: begin
        pop        = work_valid_i && (!work_i.last || out_free);
        root_start = pop && work_i.last && work_i.root;
        out_load   = pop && work_i.last && !work_i.root;
        out_d.reduced_value  = acc_upd;
        out_d.saturated_flag = ovf_upd;
      end
      BK_ROOT: begin
        out_load = !sqrt_busy && out_free;
        out_d.reduced_value  = signed'(sqrt_root);
        out_d.saturated_flag = flag_q;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // accumulator, overflow mark and output valid
  always_comb begin
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    flag_d = flag_q;
    if (pop) begin
      if (work_i.last) begin
        acc_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_upd;
        ovf_d = ovf_upd;
      end
    end
    if (root_start) begin
      flag_d = ovf_upd;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_ACC;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload and saved overflow for the root path
  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  vre_sqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .value_i(acc_upd),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for the vector reduction engine: every result checked against a predicted reduction
module tb_top;
  import vre_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned ACC_FRAC = 2 * FRAC;
  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 630;

  localparam logic [31:0] ELEM_MAX = 32'h7fff_ffff;
  localparam logic [31:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [31:0] ELEM_ONE = 32'h0001_0000;
  localparam logic [31:0] ELEM_ZERO = 32'h0000_0000;
  localparam logic signed [63:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  // register codes the engine does not define
  localparam logic [ModeW-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_RSVD7 = 3'd7;
  localparam logic [ModeW-1:0] MODE_LIST [8] = '{MODE_DOT, MODE_NORM2, MODE_NORM1,
    MODE_NORMINF, MODE_SUM, MODE_RSVD5, MODE_RSVD6, MODE_RSVD7};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ModeW-1:0] cfg_data_i = '0;

  // shadow of the engine state used for prediction
  logic [ModeW-1:0] mode_shadow = MODE_DOT;
  logic signed [63:0] acc_shadow = '0;
  logic overflow_shadow = 1'b0;
  out_item_t pending_results[$];

  int fail_count = 0;
  bit sender_eager = 1'b0;

  vector_reduction_engine_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // saturating add into the shadow accumulator
  function automatic logic signed [63:0] sat_accumulate(input logic signed [63:0] a,
                                                        input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      overflow_shadow = 1'b1;
      s = a[63] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // floor(sqrt(v * 2^ACC_FRAC)), zero for v <= 0
  function automatic logic signed [63:0] scaled_root(input logic signed [63:0] v);
    logic [127:0] target;
    logic [127:0] trial_sq;
    logic [63:0] root;
    logic [63:0] trial;
    target = (v > 0) ? ({64'd0, v} << ACC_FRAC) : 128'd0;
    root = '0;
    for (int b = 62; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      trial_sq = {64'd0, trial} * {64'd0, trial};
      if (trial_sq <= target) root = trial;
    end
    return root;
  endfunction

  // fold one accepted pair into the shadow state, queue a result on the last pair
  function automatic void reduce_pair(input in_item_t item);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] mag;
    out_item_t res;
    x = {{32{item.x_elem[31]}}, item.x_elem};
    y = {{32{item.y_elem[31]}}, item.y_elem};
    mag = x[63] ? -x : x;
    case (mode_shadow)
      MODE_DOT: acc_shadow = sat_accumulate(acc_shadow, x * y);
      MODE_NORM2: acc_shadow = sat_accumulate(acc_shadow, x * x);
      MODE_NORM1: acc_shadow = sat_accumulate(acc_shadow, mag <<< FRAC);
      MODE_NORMINF: begin
        if ((mag <<< FRAC) > acc_shadow) acc_shadow = mag <<< FRAC;
      end
      MODE_SUM: acc_shadow = sat_accumulate(acc_shadow, x <<< FRAC);
      default: ;
    endcase
    if (item.last_elem) begin
      res.reduced_value = (mode_shadow == MODE_NORM2) ? scaled_root(acc_shadow) : acc_shadow;
      res.saturated_flag = overflow_shadow;
      pending_results.push_back(res);
      acc_shadow = '0;
      overflow_shadow = 1'b0;
    end
  endfunction

  // one input transfer after a random gap
  task automatic send_pair(input logic [31:0] x, input logic [31:0] y, input logic last);
    int gap;
    in_item_t item;
    gap = sender_eager ? 0 : $urandom_range(0, 17);
    item.x_elem = x;
    item.y_elem = y;
    item.last_elem = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reduce_pair(item);
  endtask

  // stop sending, let every expected result arrive and the engine settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mode register write, only once the engine is idle
  task automatic set_mode(input logic [ModeW-1:0] m);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mode_shadow = m;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = ELEM_MAX;
      1: v = ELEM_MIN;
      2: v = ELEM_ZERO;
      3, 4, 5: begin
        v = $urandom_range(0, 1 << 18);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [ModeW-1:0] random_mode();
    return MODE_LIST[($urandom_range(0, 11) < 10) ? $urandom_range(0, 4)
                                                  : $urandom_range(5, 7)];
  endfunction

  // dot product: saturation at both limits and a pull back off the top one
  task automatic test_dot_extremes();
    set_mode(MODE_DOT);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
  endtask

  // two-norm: root of zero and of a large sum
  task automatic test_norm2();
    set_mode(MODE_NORM2);
    send_pair(ELEM_ZERO, ELEM_MAX, 1'b1);
    send_pair(ELEM_MAX, ELEM_ZERO, 1'b0);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
  endtask

  task automatic test_norm1();
    set_mode(MODE_NORM1);
    send_pair(ELEM_MIN, ELEM_ZERO, 1'b0);
    send_pair(ELEM_MAX, ELEM_ZERO, 1'b0);
    send_pair(ELEM_ZERO, ELEM_ZERO, 1'b1);
  endtask

  task automatic test_norminf();
    set_mode(MODE_NORMINF);
    send_pair(ELEM_ONE, ELEM_ZERO, 1'b0);
    send_pair(ELEM_MIN, ELEM_ZERO, 1'b0);
    send_pair(-ELEM_ONE, ELEM_ZERO, 1'b1);
  endtask

  task automatic test_sum();
    set_mode(MODE_SUM);
    send_pair(ELEM_MAX, ELEM_ZERO, 1'b0);
    send_pair(ELEM_MIN, ELEM_ZERO, 1'b1);
  endtask

  // undefined codes add nothing
  task automatic test_undefined_modes();
    set_mode(MODE_RSVD5);
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    set_mode(MODE_RSVD6);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
  endtask

  // mode written in the middle of a vector, finish uses the new mode
  task automatic test_mode_switch();
    set_mode(MODE_SUM);
    send_pair(ELEM_MAX, ELEM_ZERO, 1'b0);
    set_mode(MODE_RSVD7);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    set_mode(MODE_DOT);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    set_mode(MODE_NORM2);
    send_pair(ELEM_ZERO, ELEM_ZERO, 1'b1);
    set_mode(MODE_SUM);
    send_pair(ELEM_MIN, ELEM_ZERO, 1'b0);
    set_mode(MODE_NORMINF);
    send_pair(ELEM_ZERO, ELEM_ZERO, 1'b1);
  endtask

  // random vectors under random modes, occasional switch mid-vector
  task automatic test_random_vectors();
    int sent;
    int len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) set_mode(random_mode());
      sender_eager = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 49) == 0) set_mode(random_mode());
        send_pair(rand_elem(), rand_elem(), i == len - 1);
      end
      sent += len;
    end
    sender_eager = 1'b0;
  endtask

  // reset, then the tests in turn
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dot_extremes();
    test_norm2();
    test_norm1();
    test_norminf();
    test_sum();
    test_undefined_modes();
    test_mode_switch();
    test_random_vectors();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random stall ahead of each result, quiet stretches now and then
  initial begin : result_sink
    int hold;
    int taken;
    bit eager;
    taken = 0;
    eager = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 16 == 0) eager = ($urandom_range(0, 2) == 0);
      hold = eager ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  // result check and watchdog
  int quiet_cycles = 0;
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, got value %0d flag %0b", $time,
                   $signed(out_data_o.reduced_value), out_data_o.saturated_flag);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.reduced_value !== want.reduced_value) begin
            $display("%0t: reduced_value mismatch, expected %0d, got %0d", $time,
                     $signed(want.reduced_value), $signed(out_data_o.reduced_value));
            fail_count++;
          end
          if (out_data_o.saturated_flag !== want.saturated_flag) begin
            $display("%0t: saturated_flag mismatch, expected %0b, got %0b", $time,
                     want.saturated_flag, out_data_o.saturated_flag);
            fail_count++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
